// ===== rtl/sqc_pkg.sv =====
// Shared types and codes for the severity command queues.
`timescale 1ns / 1ps

package sqc_pkg;

  localparam int PAYLOAD_W = 32;

  // opcodes
  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_POP   = 3'd1;
  localparam logic [2:0] OP_SET   = 3'd2;
  localparam logic [2:0] OP_FLUSH = 3'd3;
  localparam logic [2:0] OP_MARK  = 3'd4;

  // severity / queue select
  localparam logic [1:0] Q_NORMAL = 2'd0;
  localparam logic [1:0] Q_HIGH   = 2'd1;
  localparam logic [1:0] Q_CRIT   = 2'd2;
  localparam logic [1:0] SEV_BAD  = 2'd3;

  // slot status
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READY = 2'd2;
  localparam logic [1:0] ST_BUSY  = 2'd3;

  // result codes
  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [2:0] RC_FULL    = 3'd1;
  localparam logic [2:0] RC_EMPTY   = 3'd2;
  localparam logic [2:0] RC_BLOCKED = 3'd3;
  localparam logic [2:0] RC_BADSEV  = 3'd4;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [1:0]           severity;
    logic [PAYLOAD_W-1:0] payload;
    logic [3:0]           entry_index;
    logic [1:0]           new_status;
  } sqc_in_t;

  typedef struct packed {
    logic [2:0]           result_code;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [3:0]           slot_id;
    logic [4:0]           fill_count;
    logic                 new_command;
  } sqc_out_t;

endpackage

// ===== rtl/sqc_ram.sv =====
// Simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module sqc_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/severity_command_queues_top.sv =====
// Top level of the three-queue severity command block (normal, high, critical).
//
// Input channel in_valid/in_stall/in_data carries one command per transaction:
// push, pop, set status, flush or mark normal head ready. Output channel
// out_valid/out_stall/out_data returns exactly one result per command.
// A command is taken only while the sequencer is idle. The accept cycle
// launches the slot status and payload RAM reads; the EVAL state then
// evaluates the command, writes back and loads the output register, and
// a new command is taken only after the sequencer returns to idle. A flush
// with pending entries then walks them in the FLUSH state, clearing one slot
// status per cycle through the single status RAM write port.
// After reset the status RAM is cleared one slot per cycle, with in_stall
// high, from slot zero through the last slot of the critical queue.
// Pointers and counts reset to zero; payload contents are undefined until
// pushed. If the receiver stalls, the result is held in the output register
// and the command being evaluated waits until the register frees.
`timescale 1ns / 1ps

module severity_command_queues_top
  import sqc_pkg::*;
#(
  parameter int NORMAL_DEPTH   = 16,
  parameter int HIGH_DEPTH     = 8,
  parameter int CRITICAL_DEPTH = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sqc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sqc_out_t out_data
);

  localparam int TOTAL = NORMAL_DEPTH + HIGH_DEPTH + CRITICAL_DEPTH;
  localparam int AW    = $clog2(TOTAL);
  localparam int MAXNH = (NORMAL_DEPTH > HIGH_DEPTH) ? NORMAL_DEPTH : HIGH_DEPTH;
  localparam int MAXD  = (MAXNH > CRITICAL_DEPTH) ? MAXNH : CRITICAL_DEPTH;
  localparam int PW    = $clog2(MAXD);
  localparam int OW    = $clog2(MAXD + 1);

  localparam logic [AW-1:0] BASE_N    = '0;
  localparam logic [AW-1:0] BASE_H    = AW'(NORMAL_DEPTH);
  localparam logic [AW-1:0] BASE_C    = AW'(NORMAL_DEPTH + HIGH_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TOTAL - 1);
  localparam logic [OW-1:0] DEP_N     = OW'(NORMAL_DEPTH);
  localparam logic [OW-1:0] DEP_H     = OW'(HIGH_DEPTH);
  localparam logic [OW-1:0] DEP_C     = OW'(CRITICAL_DEPTH);
  localparam logic [OW-1:0] OCC_ONE   = OW'(1);

  // sequencer states
  localparam logic [1:0] S_CLR   = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  function automatic logic [4:0] fill_of(input logic [OW-1:0] v);
    logic [OW+4:0] w;
    w = (OW + 5)'(v);
    return w[4:0];
  endfunction

  function automatic logic [3:0] slot_of(input logic [PW-1:0] v);
    logic [PW+3:0] w;
    w = (PW + 4)'(v);
    return w[3:0];
  endfunction

  logic [1:0]    state_r, state_nxt;
  sqc_in_t       cmd_r;
  logic [1:0]    q_r;
  logic          bad_r;
  logic [PW-1:0] rp_r [3];
  logic [PW-1:0] wp_r [3];
  logic [OW-1:0] occ_r [3];
  logic [AW-1:0] clr_cnt_r;
  logic [PW-1:0] walk_ptr_r;
  logic [OW-1:0] walk_cnt_r;
  logic          out_valid_r;
  sqc_out_t      out_data_r;

  logic          accept, go;
  logic [1:0]    in_q, sel_q;
  logic [PW-1:0] rp_sel, wp_sel, rd_off, idx_off;
  logic [OW-1:0] occ_sel, dep_sel;
  logic [AW-1:0] base_sel, rd_addr;
  logic [PW+3:0] idx_wide;
  logic          idx_ok;

  // shared wrap-increment unit
  logic [PW-1:0] wrap_in, wrap_out;
  logic [OW-1:0] wrap_sum;

  logic [1:0]          stat_rd;
  logic [PAYLOAD_W-1:0] pay_rd;

  logic          st_we, pl_we;
  logic [AW-1:0] st_waddr;
  logic [1:0]    st_wdata;
  logic          rp_we, wp_we, occ_we, walk_load, walk_step, out_load;
  logic [PW-1:0] rp_nxt, wp_nxt;
  logic [OW-1:0] occ_nxt;
  sqc_out_t      out_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign go        = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // queue select: from the input while idle, from the held command after
  assign in_q  = (in_data.opcode == OP_MARK || in_data.severity == SEV_BAD) ?
                 Q_NORMAL : in_data.severity;
  assign sel_q = (state_r == S_IDLE) ? in_q : q_r;

  assign rp_sel  = rp_r[sel_q];
  assign wp_sel  = wp_r[sel_q];
  assign occ_sel = occ_r[sel_q];

  always_comb begin
    unique case (sel_q)
      Q_HIGH: begin
        dep_sel  = DEP_H;
        base_sel = BASE_H;
      end
      Q_CRIT: begin
        dep_sel  = DEP_C;
        base_sel = BASE_C;
      end
      default: begin
        dep_sel  = DEP_N;
        base_sel = BASE_N;
      end
    endcase
  end

  // read address launched in the accept cycle
  assign rd_off  = (in_data.opcode == OP_POP || in_data.opcode == OP_MARK) ? rp_sel : wp_sel;
  assign rd_addr = base_sel + AW'(rd_off);

  // set-status slot bounds check
  assign idx_wide = (PW + 4)'(cmd_r.entry_index);
  assign idx_off  = idx_wide[PW-1:0];
  assign idx_ok   = ({{OW{1'b0}}, cmd_r.entry_index} < {4'b0000, dep_sel});

  // wrap increment: pointer + 1, back to zero at the queue depth
  assign wrap_in  = (state_r == S_FLUSH) ? walk_ptr_r :
                    ((cmd_r.opcode == OP_PUSH) ? wp_sel : rp_sel);
  assign wrap_sum = OW'(wrap_in) + OCC_ONE;
  assign wrap_out = (wrap_sum >= dep_sel) ? '0 : wrap_sum[PW-1:0];

  // slot status and payload memories
  sqc_ram #(.DEPTH(TOTAL), .WIDTH(2)) u_status (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (stat_rd)
  );

  sqc_ram #(.DEPTH(TOTAL), .WIDTH(PAYLOAD_W)) u_payload (
    .clk   (clk),
    .we    (pl_we),
    .waddr (st_waddr),
    .wdata (cmd_r.payload),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (pay_rd)
  );

  // sequencer and command evaluation
  always_comb begin
    state_nxt = state_r;
    st_we     = 1'b0;
    pl_we     = 1'b0;
    st_waddr  = base_sel + AW'(wp_sel);
    st_wdata  = ST_EMPTY;
    rp_we     = 1'b0;
    wp_we     = 1'b0;
    occ_we    = 1'b0;
    rp_nxt    = wrap_out;
    wp_nxt    = wrap_out;
    occ_nxt   = occ_sel;
    walk_load = 1'b0;
    walk_step = 1'b0;
    out_load  = 1'b0;
    out_nxt   = '0;

    unique case (state_r)
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = clr_cnt_r;
        if (clr_cnt_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (go) begin
          out_load            = 1'b1;
          state_nxt           = S_IDLE;
          out_nxt.result_code = RC_OK;
          out_nxt.fill_count  = fill_of(occ_sel);
          if (bad_r) begin
            out_nxt.result_code = RC_BADSEV;
            out_nxt.fill_count  = '0;
          end else begin
            unique case (cmd_r.opcode)
              OP_PUSH: begin
                if (occ_sel == dep_sel || stat_rd == ST_BUSY) begin
                  out_nxt.result_code = RC_FULL;
                end else begin
                  st_we               = 1'b1;
                  pl_we               = 1'b1;
                  st_wdata            = ST_IDLE;
                  wp_we               = 1'b1;
                  occ_we              = 1'b1;
                  occ_nxt             = occ_sel + OCC_ONE;
                  out_nxt.slot_id     = slot_of(wp_sel);
                  out_nxt.new_command = 1'b1;
                  out_nxt.fill_count  = fill_of(occ_sel + OCC_ONE);
                end
              end
              OP_POP: begin
                if (occ_sel == '0 || stat_rd == ST_EMPTY) begin
                  out_nxt.result_code = RC_EMPTY;
                end else if (stat_rd != ST_IDLE) begin
                  out_nxt.result_code = RC_BLOCKED;
                end else begin
                  rp_we               = 1'b1;
                  occ_we              = 1'b1;
                  occ_nxt             = occ_sel - OCC_ONE;
                  out_nxt.payload_out = pay_rd;
                  out_nxt.slot_id     = slot_of(rp_sel);
                  out_nxt.fill_count  = fill_of(occ_sel - OCC_ONE);
                end
              end
              OP_SET: begin
                if (idx_ok) begin
                  st_we    = 1'b1;
                  st_waddr = base_sel + AW'(idx_off);
                  st_wdata = cmd_r.new_status;
                end
              end
              OP_FLUSH: begin
                // pointers settle now; pending slots are cleared by the walk
                rp_we              = 1'b1;
                rp_nxt             = wp_sel;
                occ_we             = 1'b1;
                occ_nxt            = '0;
                out_nxt.fill_count = '0;
                if (occ_sel != '0) begin
                  walk_load = 1'b1;
                  state_nxt = S_FLUSH;
                end
              end
              OP_MARK: begin
                if (occ_sel != '0 && stat_rd == ST_IDLE) begin
                  st_we    = 1'b1;
                  st_waddr = base_sel + AW'(rp_sel);
                  st_wdata = ST_READY;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_FLUSH: begin
        st_we     = 1'b1;
        st_waddr  = base_sel + AW'(walk_ptr_r);
        st_wdata  = ST_EMPTY;
        walk_step = 1'b1;
        if (walk_cnt_r == OCC_ONE) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      q_r         <= Q_NORMAL;
      bad_r       <= 1'b0;
      walk_ptr_r  <= '0;
      walk_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        rp_r[i]  <= '0;
        wp_r[i]  <= '0;
        occ_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (accept) begin
        q_r   <= in_q;
        bad_r <= (in_data.severity == SEV_BAD) && (in_data.opcode != OP_MARK);
      end
      if (rp_we) begin
        rp_r[sel_q] <= rp_nxt;
      end
      if (wp_we) begin
        wp_r[sel_q] <= wp_nxt;
      end
      if (occ_we) begin
        occ_r[sel_q] <= occ_nxt;
      end
      if (walk_load) begin
        walk_ptr_r <= rp_sel;
        walk_cnt_r <= occ_sel;
      end else if (walk_step) begin
        walk_ptr_r <= wrap_out;
        walk_cnt_r <= walk_cnt_r - OCC_ONE;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

endmodule
